/* rtl/lock_order_violation_detector_assert.svh */
// Assertion macros for the lock order checker.
// Included by the top level; depends on nothing else.
`ifndef LOCK_ORDER_VIOLATION_DETECTOR_ASSERT_SVH
`define LOCK_ORDER_VIOLATION_DETECTOR_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define LOVD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Invariant checked on every rising clock edge outside reset.
`define LOVD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

/* rtl/lovd_pkg.sv */
// Shared types for the lock order checker.
// No dependencies.
package lovd_pkg;
	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;
	localparam int LOCK_W = 32;
	localparam int TID_W = 3;
	localparam int CNT_W = 4;

	// Result beat fields.
	typedef struct packed {
		logic [CNT_W-1:0] conflict_count;
		logic potential_deadlock;
		logic held_overflow;
		logic table_overflow;
	} lovd_result_t;
endpackage

/* rtl/lock_order_violation_detector.sv */
// Lock order checker top level: sequencer, held list and pair table.
// Depends on lovd_pkg, lovd_held_mem, lovd_pair_mem and the assert header.
//
// Usage: the input channel (in_valid/in_stall) carries one event beat with
// opcode, thread_id and lock_id. The output channel (out_valid/out_stall)
// returns exactly one result beat per event. One event is processed at a
// time. A release walks the thread's held list one slot at a time (read,
// then compact write). An acquire walks the held list; for each held lock
// it scans the pair table one entry at a time (read, then compare) until
// the pair is found or all stored pairs are passed. The result sits in an
// output register; a new event is taken while that beat waits, and the
// next result waits until it is taken. Reset clears the held counts, the
// pair count and the pipeline control; the memories need no clearing
// because only entries below the held count or pair count are ever read.
// A stalled receiver holds the output beat steady and freezes the
// sequencer at its finishing step.
`include "lock_order_violation_detector_assert.svh"
module lock_order_violation_detector #(
	parameter int THREADS = 8,
	parameter int MAX_HELD = 8,
	parameter int PAIR_ENTRIES = 64
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic opcode,
	input logic [lovd_pkg::TID_W-1:0] thread_id,
	input logic [lovd_pkg::LOCK_W-1:0] lock_id,
	output logic out_valid,
	input logic out_stall,
	output logic [lovd_pkg::CNT_W-1:0] conflict_count,
	output logic potential_deadlock,
	output logic held_overflow,
	output logic table_overflow
);
	import lovd_pkg::*;

	localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int HW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
	localparam int HCW = $clog2(MAX_HELD + 1);
	localparam int SLOTS = THREADS * MAX_HELD;
	localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PAW = $clog2(PAIR_ENTRIES);
	localparam int PCW = $clog2(PAIR_ENTRIES + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_HRD = 4'd1;
	localparam logic [3:0] ST_HWAIT = 4'd2;
	localparam logic [3:0] ST_PRD = 4'd3;
	localparam logic [3:0] ST_PCMP = 4'd4;
	localparam logic [3:0] ST_NEXT = 4'd5;
	localparam logic [3:0] ST_RRD = 4'd6;
	localparam logic [3:0] ST_RCMP = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0] state_q;
	logic [TW-1:0] tid_q;
	logic [LOCK_W-1:0] lock_q;
	logic [HCW-1:0] k_q;
	logic [HCW-1:0] w_q;
	logic [HCW-1:0] cnt_q [THREADS];
	logic [PCW-1:0] fill_q;
	logic [PCW-1:0] pidx_q;
	logic [LOCK_W-1:0] held_q;
	logic [CNT_W-1:0] conf_q;
	logic tov_q;
	logic hov_q;
	logic ov_valid_q;
	lovd_result_t res_q;

	// Memory ports.
	logic h_we;
	logic [SAW-1:0] h_waddr, h_raddr;
	logic [LOCK_W-1:0] h_wdata, h_rdata;
	logic p_we;
	logic [PAW-1:0] p_waddr, p_raddr;
	logic [LOCK_W-1:0] p_wlo, p_whi, p_rlo, p_rhi;
	logic p_wfirst, p_rfirst;

	lovd_held_mem #(.DEPTH(SLOTS), .AW(SAW)) u_held (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	lovd_pair_mem #(.ENTRIES(PAIR_ENTRIES), .AW(PAW)) u_pair (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wlo(p_wlo), .whi(p_whi),
		.wfirst(p_wfirst), .raddr(p_raddr), .rlo(p_rlo), .rhi(p_rhi),
		.rfirst(p_rfirst)
	);

	logic in_acc;
	logic out_acc;
	logic [HCW-1:0] n_cur;
	logic [LOCK_W-1:0] lo_w, hi_w;
	logic first_w;
	logic pmatch;

	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign n_cur = cnt_q[tid_q];

	// Ordered pair key of the held lock and the new lock.
	assign first_w = (held_q <= lock_q);
	assign lo_w = first_w ? held_q : lock_q;
	assign hi_w = first_w ? lock_q : held_q;
	assign pmatch = (p_rlo == lo_w) && (p_rhi == hi_w);

	// Memory addressing.
	always_comb begin
		h_raddr = SAW'(tid_q * MAX_HELD + k_q[HW-1:0]);
		h_we = 1'b0;
		h_waddr = SAW'(tid_q * MAX_HELD + w_q[HW-1:0]);
		h_wdata = lock_q;
		p_raddr = pidx_q[PAW-1:0];
		p_we = 1'b0;
		p_waddr = fill_q[PAW-1:0];
		p_wlo = lo_w;
		p_whi = hi_w;
		p_wfirst = first_w;
		if (state_q == ST_RCMP && h_rdata != lock_q) begin
			h_we = 1'b1;
			h_wdata = h_rdata;
		end
		if (state_q == ST_NEXT && k_q == n_cur && n_cur < HCW'(MAX_HELD)) begin
			h_we = 1'b1;
			h_waddr = SAW'(tid_q * MAX_HELD + n_cur[HW-1:0]);
		end
		if (state_q == ST_PCMP && pidx_q == fill_q && fill_q < PCW'(PAIR_ENTRIES)) begin
			p_we = 1'b1;
		end
	end

	// Event sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			ov_valid_q <= 1'b0;
			for (int t = 0; t < THREADS; t++) begin
				cnt_q[t] <= '0;
			end
		end else begin
			if (out_acc) begin
				ov_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						tid_q <= TW'(thread_id);
						lock_q <= lock_id;
						k_q <= '0;
						w_q <= '0;
						conf_q <= '0;
						tov_q <= 1'b0;
						hov_q <= 1'b0;
						if (32'(thread_id) >= 32'(THREADS)) begin
							state_q <= ST_DONE;
						end else if (opcode == OP_RELEASE) begin
							state_q <= ST_RRD;
						end else begin
							state_q <= ST_HRD;
						end
					end
				end
				// Release: compact the list in place.
				ST_RRD: begin
					if (k_q == n_cur) begin
						cnt_q[tid_q] <= w_q;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_RCMP;
					end
				end
				ST_RCMP: begin
					if (h_rdata != lock_q) begin
						w_q <= w_q + 1'b1;
					end
					k_q <= k_q + 1'b1;
					state_q <= ST_RRD;
				end
				// Acquire: fetch the next held lock.
				ST_HRD: begin
					if (k_q == n_cur) begin
						state_q <= ST_NEXT;
					end else begin
						state_q <= ST_HWAIT;
					end
				end
				ST_HWAIT: begin
					held_q <= h_rdata;
					pidx_q <= '0;
					state_q <= ST_PRD;
				end
				ST_PRD: begin
					state_q <= ST_PCMP;
				end
				// Compare one stored pair, or store the pair at the end if the table has room.
				ST_PCMP: begin
					if (pidx_q == fill_q) begin
						if (fill_q < PCW'(PAIR_ENTRIES)) begin
							fill_q <= fill_q + 1'b1;
						end else begin
							tov_q <= 1'b1;
						end
						k_q <= k_q + 1'b1;
						state_q <= ST_HRD;
					end else if (pmatch) begin
						if (held_q != lock_q && p_rfirst != first_w && conf_q != '1) begin
							conf_q <= conf_q + 1'b1;
						end
						k_q <= k_q + 1'b1;
						state_q <= ST_HRD;
					end else begin
						pidx_q <= pidx_q + 1'b1;
						state_q <= ST_PRD;
					end
				end
				ST_NEXT: begin
					if (n_cur < HCW'(MAX_HELD)) begin
						cnt_q[tid_q] <= n_cur + 1'b1;
					end else begin
						hov_q <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!ov_valid_q || out_acc) begin
						ov_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!ov_valid_q || out_acc)) begin
			res_q.conflict_count <= conf_q;
			res_q.potential_deadlock <= (conf_q != '0);
			res_q.held_overflow <= hov_q;
			res_q.table_overflow <= tov_q;
		end
	end

	assign out_valid = ov_valid_q;
	assign conflict_count = res_q.conflict_count;
	assign potential_deadlock = res_q.potential_deadlock;
	assign held_overflow = res_q.held_overflow;
	assign table_overflow = res_q.table_overflow;

	`LOVD_ASSERT_ALWAYS(a_fill_range, clk, arst_n, fill_q <= PCW'(PAIR_ENTRIES), "pair count beyond table")
	`LOVD_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !in_acc, "event taken while busy")
	`LOVD_ASSERT_IMP(a_flag_match, clk, arst_n, out_valid, potential_deadlock == (conflict_count != '0), "deadlock flag mismatch")
endmodule

/* rtl/lovd_pair_mem.sv */
// Pair table memory: lock pair keys and first order bit, one write and one
// registered read per cycle. Depends on lovd_pkg.
module lovd_pair_mem #(
	parameter int ENTRIES = 64,
	parameter int AW = 6
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [lovd_pkg::LOCK_W-1:0] wlo,
	input logic [lovd_pkg::LOCK_W-1:0] whi,
	input logic wfirst,
	input logic [AW-1:0] raddr,
	output logic [lovd_pkg::LOCK_W-1:0] rlo,
	output logic [lovd_pkg::LOCK_W-1:0] rhi,
	output logic rfirst
);
	import lovd_pkg::*;
	logic [2*LOCK_W:0] mem [ENTRIES];

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wfirst, whi, wlo};
		end
		{rfirst, rhi, rlo} <= mem[raddr];
	end
endmodule

/* rtl/lovd_held_mem.sv */
// Held lock memory: one lock id per thread slot, registered read.
// Depends on lovd_pkg.
module lovd_held_mem #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [lovd_pkg::LOCK_W-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [lovd_pkg::LOCK_W-1:0] rdata
);
	import lovd_pkg::*;
	logic [LOCK_W-1:0] mem [DEPTH];

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* tb/sv/lock_order_violation_detector_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the lock order checker: drives acquire and release
// beats, predicts each result beat and compares it. Depends on lovd_pkg and the RTL.
module lock_order_violation_detector_tb;
	import lovd_pkg::*;

	localparam int N_THREADS = 8;
	localparam int HELD_DEPTH = 8;
	localparam int PAIR_DEPTH = 64;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_ITEMS = 60;

	typedef struct {
		logic op;
		logic [TID_W-1:0] tid;
		logic [LOCK_W-1:0] lock;
	} lock_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = OP_ACQUIRE;
	logic [TID_W-1:0] thread_id = '0;
	logic [LOCK_W-1:0] lock_id = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CNT_W-1:0] conflict_count;
	logic potential_deadlock;
	logic held_overflow;
	logic table_overflow;

	lock_event_t pending_events[$];
	lovd_result_t expected_results[$];
	int errors = 0;
	int send_gap = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	bit tail_phase = 1'b0;

	// Shadow copy of the held lists and the pair table.
	logic [LOCK_W-1:0] shadow_held[N_THREADS][HELD_DEPTH];
	int shadow_held_n[N_THREADS];
	logic [LOCK_W-1:0] shadow_pair_lo[PAIR_DEPTH];
	logic [LOCK_W-1:0] shadow_pair_hi[PAIR_DEPTH];
	logic shadow_pair_lo_first[PAIR_DEPTH];
	int shadow_pair_fill = 0;

	lock_order_violation_detector u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .thread_id(thread_id), .lock_id(lock_id),
		.out_valid(out_valid), .out_stall(out_stall),
		.conflict_count(conflict_count), .potential_deadlock(potential_deadlock),
		.held_overflow(held_overflow), .table_overflow(table_overflow)
	);

	always #5 clk = ~clk;

	// Apply one event to the shadow state and return the result it should give.
	function automatic lovd_result_t predict_lock_event(lock_event_t ev);
		lovd_result_t res;
		int t;
		int w;
		int hit;
		int conflicts;
		logic [LOCK_W-1:0] h;
		logic [LOCK_W-1:0] lo;
		logic [LOCK_W-1:0] hi;
		logic lo_first;
		res = '0;
		t = ev.tid;
		conflicts = 0;
		if (t >= N_THREADS) return res;
		if (ev.op == OP_RELEASE) begin
			// Compact the list, dropping every copy of the released lock.
			w = 0;
			for (int k = 0; k < shadow_held_n[t]; k++) begin
				if (shadow_held[t][k] != ev.lock) begin
					shadow_held[t][w] = shadow_held[t][k];
					w++;
				end
			end
			shadow_held_n[t] = w;
			return res;
		end
		for (int k = 0; k < shadow_held_n[t]; k++) begin
			h = shadow_held[t][k];
			lo_first = (h <= ev.lock);
			lo = lo_first ? h : ev.lock;
			hi = lo_first ? ev.lock : h;
			hit = -1;
			for (int i = 0; i < shadow_pair_fill; i++) begin
				if (hit < 0 && shadow_pair_lo[i] == lo && shadow_pair_hi[i] == hi) hit = i;
			end
			if (hit >= 0) begin
				if (h != ev.lock && shadow_pair_lo_first[hit] != lo_first && conflicts < 15)
					conflicts++;
			end else if (shadow_pair_fill < PAIR_DEPTH) begin
				shadow_pair_lo[shadow_pair_fill] = lo;
				shadow_pair_hi[shadow_pair_fill] = hi;
				shadow_pair_lo_first[shadow_pair_fill] = lo_first;
				shadow_pair_fill++;
			end else begin
				res.table_overflow = 1'b1;
			end
		end
		if (shadow_held_n[t] < HELD_DEPTH) begin
			shadow_held[t][shadow_held_n[t]] = ev.lock;
			shadow_held_n[t]++;
		end else begin
			res.held_overflow = 1'b1;
		end
		res.conflict_count = conflicts[CNT_W-1:0];
		res.potential_deadlock = (conflicts != 0);
		return res;
	endfunction

	task automatic add_event(logic op, int tid, logic [LOCK_W-1:0] lock);
		lock_event_t ev;
		ev.op = op;
		ev.tid = tid[TID_W-1:0];
		ev.lock = lock;
		pending_events.insert(pending_events.size(), ev);
	endtask

	// Driver: predicts each accepted beat, then presents the next one.
	always @(posedge clk or negedge arst_n) begin
		lock_event_t ev;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				ev.op = opcode;
				ev.tid = thread_id;
				ev.lock = lock_id;
				expected_results.insert(expected_results.size(), predict_lock_event(ev));
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_events.size() > 0) begin
					ev = pending_events.pop_front();
					opcode <= ev.op;
					thread_id <= ev.tid;
					lock_id <= ev.lock;
					in_valid <= 1'b1;
					if (pending_events.size() < TAIL_ITEMS) tail_phase = 1'b1;
					if (!tail_phase && $urandom_range(3) == 0) send_gap = $urandom_range(1, 7);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each accepted result beat and applies receiver stalls.
	always @(posedge clk or negedge arst_n) begin
		lovd_result_t got;
		lovd_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got.conflict_count = conflict_count;
				got.potential_deadlock = potential_deadlock;
				got.held_overflow = held_overflow;
				got.table_overflow = table_overflow;
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with none expected: count %0d dl %b hov %b tov %b",
						$time, got.conflict_count, got.potential_deadlock,
						got.held_overflow, got.table_overflow);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						$display(
							"%0t: expected cnt %0d dl %b hov %b tov %b, actual cnt %0d dl %b hov %b tov %b",
							$time, want.conflict_count, want.potential_deadlock,
							want.held_overflow, want.table_overflow, got.conflict_count,
							got.potential_deadlock, got.held_overflow, got.table_overflow);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!tail_phase && $urandom_range(4) == 0) begin
				stall_left = $urandom_range(0, 6);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: ends the run if no beat moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("lock_order_violation_detector test failed");
			$finish;
		end
	end

	initial begin
		logic [LOCK_W-1:0] lock_pool[6];
		for (int t = 0; t < N_THREADS; t++) shadow_held_n[t] = 0;
		lock_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0010, 32'h8000_0000,
			32'h1234_5678, 32'h7FFF_FFFF};

		// Directed: opposite orders, self pairs, duplicate copies, full list, releases.
		add_event(OP_ACQUIRE, 0, 32'h0000_0000);
		add_event(OP_ACQUIRE, 0, 32'hFFFF_FFFF);
		add_event(OP_ACQUIRE, 1, 32'hFFFF_FFFF);
		add_event(OP_ACQUIRE, 1, 32'h0000_0000);
		add_event(OP_ACQUIRE, 1, 32'h0000_0000);
		add_event(OP_ACQUIRE, 1, 32'hFFFF_FFFF);
		add_event(OP_RELEASE, 1, 32'h0000_0000);
		add_event(OP_RELEASE, 1, 32'h5555_AAAA);
		add_event(OP_RELEASE, 0, 32'h0000_0000);
		add_event(OP_RELEASE, 0, 32'hFFFF_FFFF);
		for (int k = 0; k < 10; k++) add_event(OP_ACQUIRE, 7, 32'h100 + k);
		add_event(OP_RELEASE, 7, 32'h0000_0105);
		add_event(OP_ACQUIRE, 7, 32'h0000_0100);
		add_event(OP_RELEASE, 1, 32'hFFFF_FFFF);

		// Random beats over a small lock pool, so that orders repeat and conflict.
		for (int k = 0; k < 460; k++)
			add_event($urandom_range(99) < 55 ? OP_ACQUIRE : OP_RELEASE,
				$urandom_range(N_THREADS - 1), lock_pool[$urandom_range(5)]);
		// Wide random locks: cover every lock bit and fill the pair table.
		for (int k = 0; k < 140; k++)
			add_event($urandom_range(99) < 70 ? OP_ACQUIRE : OP_RELEASE,
				$urandom_range(N_THREADS - 1),
				$urandom_range(2) == 0 ? lock_pool[$urandom_range(5)] : $urandom);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_events.size() == 0 && !in_valid && expected_results.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("lock_order_violation_detector test passed");
		end else begin
			$display("lock_order_violation_detector test failed");
		end
		$finish;
	end
endmodule
